// File: rtl/mav_pkg.sv
package mav_pkg;

    localparam int IDX_W    = 6;
    localparam int SCORE_W  = 32;
    localparam int ADDR_W   = 12;
    localparam int NCELLS   = 4096;
    localparam int LEN_W    = 7;

    localparam logic signed [SCORE_W-1:0] NEG_INF   = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-2){1'b0}}, 1'b1};

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_FWD_RD,
        ST_FWD_WAIT,
        ST_FWD_WR,
        ST_BT_RD,
        ST_BT_WAIT,
        ST_BT_EMIT,
        ST_ERR
    } state_t;

    // Saturating add in which minus infinity absorbs.
    function automatic logic signed [SCORE_W-1:0] sat_add(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [SCORE_W-1:0] b
    );
        logic signed [SCORE_W:0] sum;
        begin
            sum = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
            if (a == NEG_INF || b == NEG_INF)
                sat_add = NEG_INF;
            else if (sum > $signed({1'b0, SCORE_MAX}))
                sat_add = SCORE_MAX;
            else if (sum < $signed({SCORE_MIN[SCORE_W-1], SCORE_MIN}))
                sat_add = SCORE_MIN;
            else
                sat_add = sum[SCORE_W-1:0];
        end
    endfunction

endpackage

// File: rtl/mav_ram.sv
module mav_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/monotonic_alignment_viterbi_unit.sv
// Monotonic alignment search. Cells are loaded one per transfer into a cell RAM.
// The transfer marked last starts the run, during which no cell is taken. The
// run first checks the lengths. The forward pass then handles each banded cell
// (t,s) for t >= 1 by a read, a wait and a write back when it has one
// predecessor in row t-1, and reads and waits twice when it has two, since the
// path-score RAM has a single read port. The backtrack emits the cell of the
// last row, then reads the predecessors of the cell below each further row the
// same way, emitting the path from the last row down to row 0; output stalls
// can hold it. Over T rows and S columns the band holds at most
// min(S, T-S+1) cells per row. Path scores outside the band are never read,
// so that RAM needs no clearing pass.
module monotonic_alignment_viterbi_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [mav_pkg::IDX_W-1:0]         tgt_index,
    input  logic [mav_pkg::IDX_W-1:0]         src_index,
    input  logic signed [mav_pkg::SCORE_W-1:0] cell_score,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mav_pkg::IDX_W-1:0]         row_out,
    output logic [mav_pkg::IDX_W-1:0]         col_out,
    output logic                              status,
    output logic                              final_res
);

    localparam int IW = mav_pkg::IDX_W;
    localparam int SW = mav_pkg::SCORE_W;
    localparam int AW = mav_pkg::ADDR_W;
    localparam int LW = mav_pkg::LEN_W;

    mav_pkg::state_t state_reg, state_next;
    logic [63:0] row_mask_reg, col_mask_reg;
    logic [LW-1:0] row_cnt_reg, col_cnt_reg;
    logic [LW-1:0] tl_reg, sl_reg;
    logic [IW-1:0] t_reg, t_next, s_reg, s_next, en_reg, en_next;
    logic          k_reg, k_next;
    logic signed [SW-1:0] m_reg, m_next;
    logic [IW-1:0] best_reg, best_next;
    logic          out_valid_reg;
    logic [IW-1:0] row_reg, col_reg;
    logic          status_reg, final_reg;

    logic          in_xfer;
    logic [LW-1:0] tl_cnt, sl_cnt;

    // RAM ports.
    logic          cell_we, path_we;
    logic [AW-1:0] cell_waddr, cell_raddr, path_waddr, path_raddr;
    logic [SW-1:0] cell_wdata, cell_rdata, path_wdata, path_rdata;

    mav_ram #(.WIDTH(SW), .DEPTH(mav_pkg::NCELLS)) u_cell_ram (
        .clk(clk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
        .raddr(cell_raddr), .rdata(cell_rdata)
    );

    mav_ram #(.WIDTH(SW), .DEPTH(mav_pkg::NCELLS)) u_path_ram (
        .clk(clk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
        .raddr(path_raddr), .rdata(path_rdata)
    );

    assign in_stall = (state_reg != mav_pkg::ST_LOAD);
    assign in_xfer  = in_valid && !in_stall;

    // Counts of marked rows and columns, kept up to date while loading.
    assign tl_cnt = row_cnt_reg;
    assign sl_cnt = col_cnt_reg;

    // Band of row t: columns from max(0, S+t-T) to min(t, S-1).
    logic [IW-1:0] t_plus, band_st, band_en;
    logic [LW-1:0] st_sum;
    always_comb
    begin
        t_plus  = t_reg + IW'(1);
        st_sum  = sl_reg + LW'(t_reg);
        band_st = (st_sum > tl_reg) ? IW'(st_sum - tl_reg) : '0;
        band_en = (LW'(t_reg) < sl_reg - LW'(1)) ? t_reg : IW'(sl_reg - LW'(1));
    end

    // Predecessor columns of (t,s): lo = s-1 (or 0), hi = min(t-1, s).
    logic [IW-1:0] pred_lo, pred_hi, pred_col;
    logic          two_pred;
    always_comb
    begin
        pred_lo  = (s_reg != '0) ? s_reg - IW'(1) : '0;
        pred_hi  = ((t_reg - IW'(1)) < s_reg) ? t_reg - IW'(1) : s_reg;
        two_pred = (pred_hi != pred_lo);
        pred_col = k_reg ? pred_hi : pred_lo;
    end

    logic signed [SW-1:0] cand;
    logic                 take;
    logic signed [SW-1:0] load_val;
    always_comb
    begin
        // Path score of (0,0) is zero and never stored.
        cand = (t_reg == IW'(1)) ? '0 : $signed(path_rdata);
        take = !k_reg || (cand > m_reg);
        if (cell_score == mav_pkg::NEG_INF)
            load_val = mav_pkg::NEG_INF;
        else
            load_val = cell_score;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mav_pkg::ST_LOAD:
                if (in_xfer && last) state_next = mav_pkg::ST_START;
            mav_pkg::ST_START:
                if (tl_cnt == '0 || sl_cnt == '0 || sl_cnt > tl_cnt)
                    state_next = mav_pkg::ST_ERR;
                else if (tl_cnt == LW'(1))
                    state_next = mav_pkg::ST_BT_EMIT;
                else
                    state_next = mav_pkg::ST_FWD_RD;
            mav_pkg::ST_FWD_RD:   state_next = mav_pkg::ST_FWD_WAIT;
            mav_pkg::ST_FWD_WAIT:
                if (k_reg || !two_pred) state_next = mav_pkg::ST_FWD_WR;
                else                    state_next = mav_pkg::ST_FWD_RD;
            mav_pkg::ST_FWD_WR:
                if (s_reg == en_reg && LW'(t_reg) == tl_reg - LW'(1))
                    state_next = mav_pkg::ST_BT_EMIT;
                else
                    state_next = mav_pkg::ST_FWD_RD;
            mav_pkg::ST_BT_RD:    state_next = mav_pkg::ST_BT_WAIT;
            mav_pkg::ST_BT_WAIT:
                if (k_reg || !two_pred) state_next = mav_pkg::ST_BT_EMIT;
                else                    state_next = mav_pkg::ST_BT_RD;
            mav_pkg::ST_BT_EMIT:
                if (!out_valid_reg || !out_stall)
                    state_next = (t_reg == '0) ? mav_pkg::ST_LOAD : mav_pkg::ST_BT_RD;
            mav_pkg::ST_ERR:
                if (!out_valid_reg || !out_stall) state_next = mav_pkg::ST_LOAD;
            default: state_next = mav_pkg::ST_LOAD;
        endcase
    end

    // Datapath controls and RAM accesses.
    always_comb
    begin
        t_next = t_reg;
        s_next = s_reg;
        en_next = en_reg;
        k_next = k_reg;
        m_next = m_reg;
        best_next = best_reg;
        cell_we = in_xfer;
        cell_waddr = {tgt_index, src_index};
        cell_wdata = load_val;
        cell_raddr = {t_reg, s_reg};
        path_we = 1'b0;
        path_waddr = {t_reg, s_reg};
        path_wdata = mav_pkg::sat_add(m_reg, $signed(cell_rdata));
        path_raddr = {t_reg - IW'(1), pred_col};
        case (state_reg)
            mav_pkg::ST_START:
            begin
                t_next = IW'(1);
                s_next = '0;
                en_next = '0;
                k_next = 1'b0;
            end
            mav_pkg::ST_FWD_RD:
            begin
                // First cell of a row: load the band limits.
                if (s_reg == '0 && en_reg == '0 && !k_reg)
                begin
                    s_next = band_st;
                    en_next = band_en;
                end
            end
            mav_pkg::ST_FWD_WAIT:
            begin
                if (take) m_next = cand;
                k_next = !k_reg && two_pred;
            end
            mav_pkg::ST_FWD_WR:
            begin
                path_we = 1'b1;
                k_next = 1'b0;
                if (s_reg == en_reg)
                begin
                    t_next = t_plus;
                    s_next = '0;
                    en_next = '0;
                end
                else
                begin
                    s_next = s_reg + IW'(1);
                end
            end
            mav_pkg::ST_BT_RD: ;
            mav_pkg::ST_BT_WAIT:
            begin
                if (take)
                begin
                    m_next = cand;
                    best_next = pred_col;
                end
                k_next = !k_reg && two_pred;
                // The chosen column belongs to the row above.
                if (k_reg || !two_pred)
                    t_next = t_reg - IW'(1);
            end
            mav_pkg::ST_BT_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    k_next = 1'b0;
                    s_next = best_reg;
                end
            end
            default: ;
        endcase
        // Entering the backtrack from the forward pass or a one-row run.
        if (state_reg != mav_pkg::ST_BT_EMIT && state_next == mav_pkg::ST_BT_EMIT
            && state_reg != mav_pkg::ST_BT_WAIT)
        begin
            t_next = IW'((state_reg == mav_pkg::ST_START ? tl_cnt : tl_reg) - LW'(1));
            best_next = IW'((state_reg == mav_pkg::ST_START ? sl_cnt : sl_reg) - LW'(1));
        end
        // At a row start (s/en and k cleared) the reads use the band's first column.
        if (state_reg == mav_pkg::ST_FWD_RD && s_reg == '0 && en_reg == '0 && !k_reg)
            cell_raddr = {t_reg, band_st};
        if (state_reg == mav_pkg::ST_FWD_RD && s_reg == '0 && en_reg == '0 && !k_reg)
            path_raddr = {t_reg - IW'(1), (band_st != '0) ? band_st - IW'(1) : IW'(0)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mav_pkg::ST_LOAD;
            row_mask_reg <= '0;
            col_mask_reg <= '0;
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            k_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
            // Masks and counts of nonempty rows and columns.
            if (state_reg == mav_pkg::ST_START)
            begin
                row_mask_reg <= '0;
                col_mask_reg <= '0;
                row_cnt_reg <= '0;
                col_cnt_reg <= '0;
            end
            else if (in_xfer && cell_score != mav_pkg::NEG_INF)
            begin
                row_mask_reg[tgt_index] <= 1'b1;
                col_mask_reg[src_index] <= 1'b1;
                if (!row_mask_reg[tgt_index])
                    row_cnt_reg <= row_cnt_reg + LW'(1);
                if (!col_mask_reg[src_index])
                    col_cnt_reg <= col_cnt_reg + LW'(1);
            end
            if ((state_reg == mav_pkg::ST_BT_EMIT || state_reg == mav_pkg::ST_ERR)
                && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        s_reg <= s_next;
        en_reg <= en_next;
        m_reg <= m_next;
        best_reg <= best_next;
        if (state_reg == mav_pkg::ST_START)
        begin
            tl_reg <= tl_cnt;
            sl_reg <= sl_cnt;
        end
        if (state_reg == mav_pkg::ST_BT_EMIT && (!out_valid_reg || !out_stall))
        begin
            row_reg <= t_reg;
            col_reg <= best_reg;
            status_reg <= 1'b0;
            final_reg <= (t_reg == '0);
        end
        if (state_reg == mav_pkg::ST_ERR && (!out_valid_reg || !out_stall))
        begin
            row_reg <= '0;
            col_reg <= '0;
            status_reg <= 1'b1;
            final_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_out = row_reg;
    assign col_out = col_reg;
    assign status = status_reg;
    assign final_res = final_reg;

    // No cell is taken while a run is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mav_pkg::ST_LOAD) |-> in_stall)
        else $error("cell taken during a run");

    // An error result is always the final one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> final_res)
        else $error("error result not final");

    // A held result does not change while stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid && out_stall) |-> $stable(row_out) && $stable(col_out))
        else $error("stalled result changed");

endmodule
